### rtl/ulcc_pkg.sv
// Shared types, constants and the CRC-32 byte update for the upload checker.
`default_nettype none
package ulcc_pkg;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam int CSR_AW = 2;
   localparam int CSR_DW = 24;

   localparam logic [23:0] MAX_UPLOAD_RESET   = 24'd1048576;
   localparam logic [15:0] ACK_EVERY_RESET    = 16'd8;
   localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd5000;

   typedef enum logic [CSR_AW-1:0] {
      REG_MAX_UPLOAD   = 2'd0,
      REG_ACK_EVERY    = 2'd1,
      REG_IDLE_TIMEOUT = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      MODE_BEGIN    = 3'd0,
      MODE_DATA     = 3'd1,
      MODE_DATA_END = 3'd2,
      MODE_END      = 3'd3,
      MODE_TICK     = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      OP_BEGIN,
      OP_DATA,
      OP_DATA_END,
      OP_END,
      OP_TICK
   } op_type;

   typedef enum logic [3:0] {
      EV_ACK       = 4'd0,
      EV_OK        = 4'd1,
      EV_RESTARTED = 4'd2,
      EV_BAD_SIZE  = 4'd3,
      EV_TOO_LONG  = 4'd4,
      EV_TIMEOUT   = 4'd5,
      EV_NO_UPLOAD = 4'd6,
      EV_SHORT     = 4'd7,
      EV_CHECKSUM  = 4'd8
   } event_type;

   typedef struct packed {
      op_type      op;
      logic        bad_size;
      logic [23:0] size;
      logic [31:0] crc;
      logic [7:0]  data;
   } item_type;

   typedef struct packed {
      event_type   ev;
      logic [23:0] count;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [23:0] max_upload;
      logic [15:0] ack_every;
      logic [15:0] idle_timeout;
   } cfg_type;

   // one byte through the reflected CRC register (uninverted form)
   function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
      logic [31:0] c;
      c = crc_in ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

### rtl/ulcc_queue.sv
// Short item queue between the classifier and the executor.
`default_nettype none
module ulcc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ulcc_pkg::item_type push_item,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output ulcc_pkg::item_type     head_item
);

   ulcc_pkg::item_type            mem_ff [ulcc_pkg::QUEUE_DEPTH];
   logic [ulcc_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ulcc_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ulcc_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic                          do_push, do_pop;

   assign full       = (count_ff == (ulcc_pkg::QUEUE_AW+1)'(ulcc_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

### rtl/ulcc_front.sv
// Input side: accepts items, decodes the mode and checks the declared size.
`default_nettype none
module ulcc_front (
   input  wire logic              req_tvalid,
   input  wire logic [2:0]        req_mode,
   input  wire logic [71:0]       req_payload,
   input  wire ulcc_pkg::cfg_type cfg,
   input  wire logic              queue_full,
   output logic                   req_ready,
   output logic                   push,
   output ulcc_pkg::item_type     item
);

   logic [31:0] size;
   logic        known;

   assign size      = req_payload[31:0];
   assign req_ready = !queue_full;

   always_comb begin
      item.op       = ulcc_pkg::OP_TICK;
      known         = 1'b1;
      unique case (req_mode)
         ulcc_pkg::MODE_BEGIN:    item.op = ulcc_pkg::OP_BEGIN;
         ulcc_pkg::MODE_DATA:     item.op = ulcc_pkg::OP_DATA;
         ulcc_pkg::MODE_DATA_END: item.op = ulcc_pkg::OP_DATA_END;
         ulcc_pkg::MODE_END:      item.op = ulcc_pkg::OP_END;
         ulcc_pkg::MODE_TICK:     item.op = ulcc_pkg::OP_TICK;
         default:                 known   = 1'b0;
      endcase
      item.bad_size = (size == 32'd0) || (size > {8'd0, cfg.max_upload});
      item.size     = size[23:0];
      item.crc      = req_payload[63:32];
      item.data     = req_payload[71:64];
   end

   // unused modes are taken and dropped here
   assign push = req_tvalid && !queue_full && known;

endmodule
`default_nettype wire

### rtl/ulcc_back.sv
// Executor: upload state, CRC, counters and the result output stage.
`default_nettype none
module ulcc_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ulcc_pkg::cfg_type  cfg,
   input  wire logic               head_valid,
   input  wire ulcc_pkg::item_type head_item,
   output logic                    pop,
   output logic                    rsp_valid,
   output ulcc_pkg::result_type    rsp_result,
   input  wire logic               rsp_ready
);

   logic        active_ff, active_in;
   logic [23:0] target_size_ff, target_size_in;
   logic [31:0] target_crc_ff, target_crc_in;
   logic [31:0] crc_ff, crc_in;
   logic [23:0] count_ff, count_in;
   logic [15:0] chunks_ff, chunks_in;
   logic [16:0] idle_ff, idle_in;

   logic                 out_valid_ff, out_valid_in;
   ulcc_pkg::result_type out_ff, out_in;
   logic                 pend_valid_ff, pend_valid_in;
   ulcc_pkg::result_type pend_ff, pend_in;

   ulcc_pkg::result_type res0, res1;
   logic [1:0]           n_res;
   logic                 out_free;
   logic [23:0]          count_inc;
   logic [15:0]          chunks_inc;
   logic [16:0]          idle_inc;
   logic [16:0]          timeout_ext;

   assign count_inc   = count_ff + 24'd1;
   assign chunks_inc  = chunks_ff + 16'd1;
   assign timeout_ext = {1'b0, cfg.idle_timeout};
   assign idle_inc    = (idle_ff <= timeout_ext) ? idle_ff + 17'd1 : idle_ff;

   always_comb begin
      active_in      = active_ff;
      target_size_in = target_size_ff;
      target_crc_in  = target_crc_ff;
      crc_in         = crc_ff;
      count_in       = count_ff;
      chunks_in      = chunks_ff;
      idle_in        = idle_ff;
      n_res          = 2'd0;
      res0           = '{ev: ulcc_pkg::EV_ACK, count: count_ff, last: 1'b1};
      res1           = '{ev: ulcc_pkg::EV_ACK, count: 24'd0, last: 1'b1};
      unique case (head_item.op)
         ulcc_pkg::OP_BEGIN: begin
            if (active_ff) begin
               res0.ev   = ulcc_pkg::EV_RESTARTED;
               res0.last = 1'b0;
               n_res     = 2'd2;
            end else begin
               n_res = 2'd1;
            end
            if (head_item.bad_size) begin
               res1.ev   = ulcc_pkg::EV_BAD_SIZE;
               res1.count = head_item.size;
               active_in = 1'b0;
            end else begin
               res1.ev        = ulcc_pkg::EV_ACK;
               target_size_in = head_item.size;
               target_crc_in  = head_item.crc;
               crc_in         = '1;
               count_in       = '0;
               chunks_in      = '0;
               idle_in        = '0;
               active_in      = 1'b1;
            end
            if (!active_ff) begin
               res0 = res1;
            end
         end
         ulcc_pkg::OP_DATA, ulcc_pkg::OP_DATA_END: begin
            if (active_ff) begin
               idle_in = '0;
               if (count_ff >= target_size_ff) begin
                  active_in = 1'b0;
                  res0.ev   = ulcc_pkg::EV_TOO_LONG;
                  n_res     = 2'd1;
               end else begin
                  crc_in   = ulcc_pkg::crc_byte(crc_ff, head_item.data);
                  count_in = count_inc;
                  if (head_item.op == ulcc_pkg::OP_DATA_END) begin
                     chunks_in = chunks_inc;
                     if (chunks_inc >= cfg.ack_every) begin
                        chunks_in  = '0;
                        res0.ev    = ulcc_pkg::EV_ACK;
                        res0.count = count_inc;
                        n_res      = 2'd1;
                     end
                  end
               end
            end
         end
         ulcc_pkg::OP_END: begin
            n_res = 2'd1;
            if (!active_ff) begin
               res0.ev    = ulcc_pkg::EV_NO_UPLOAD;
               res0.count = '0;
            end else begin
               active_in = 1'b0;
               if (count_ff != target_size_ff) begin
                  res0.ev = ulcc_pkg::EV_SHORT;
               end else if (~crc_ff != target_crc_ff) begin
                  res0.ev = ulcc_pkg::EV_CHECKSUM;
               end else begin
                  res0.ev = ulcc_pkg::EV_OK;
               end
            end
         end
         ulcc_pkg::OP_TICK: begin
            if (active_ff) begin
               idle_in = idle_inc;
               if (idle_inc > timeout_ext) begin
                  active_in = 1'b0;
                  res0.ev   = ulcc_pkg::EV_TIMEOUT;
                  n_res     = 2'd1;
               end
            end
         end
         default: n_res = 2'd0;
      endcase
   end

   assign out_free = !out_valid_ff || rsp_ready;
   assign pop      = head_valid && !pend_valid_ff && (out_free || n_res == 2'd0);

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (pend_valid_ff && out_free) begin
         out_valid_in  = 1'b1;
         out_in        = pend_ff;
         pend_valid_in = 1'b0;
      end else if (pop && n_res != 2'd0) begin
         out_valid_in = 1'b1;
         out_in       = res0;
         if (n_res == 2'd2) begin
            pend_valid_in = 1'b1;
            pend_in       = res1;
         end
      end else if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
         if (pop) begin
            active_ff <= active_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
      if (pop) begin
         target_size_ff <= target_size_in;
         target_crc_ff  <= target_crc_in;
         crc_ff         <= crc_in;
         count_ff       <= count_in;
         chunks_ff      <= chunks_in;
         idle_ff        <= idle_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

   a_pend_behind_out: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> out_valid_ff)
      else $error("second result held without a first in the output stage");

   a_no_pop_with_pend: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> !pop)
      else $error("item taken while a second result is still pending");

   a_close_reports: assert property (@(posedge clock) disable iff (reset)
      $fell(active_ff) |-> out_valid_ff)
      else $error("upload closed without a result");

endmodule
`default_nettype wire

### rtl/upload_length_crc_checker_core.sv
// Top level of the upload length and CRC-32 checker.
//
// req channel: one item per transfer; req_tuser holds the mode (begin, data,
// data ending a chunk, end, tick), req_tdata the declared size, the expected
// CRC and the data byte. rsp channel: one result per transfer; rsp_tuser is
// the event code, rsp_tdata the byte count, rsp_tlast marks the final result
// caused by an item. csr_we/csr_addr/csr_wdata write the size limit, the ack
// interval and the idle timeout; writes to unknown indexes are dropped.
// An accepted item sits in a four-entry queue; the executor takes one item
// per cycle unless a pending result or a stalled output stage holds it, and
// each result is registered in the output stage. A begin that restarts an
// open upload gives two results and holds the executor until the second
// leaves the pending register. The CRC byte update is combinational.
// When rsp_tready is low, results wait in the output stage and the queue
// fills; req_tready drops once the queue is full.
// Reset clears the queue, the output stage and the open upload, and loads
// the registers with their default values.
`default_nettype none
module upload_length_crc_checker_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [71:0]                 req_tdata,  // declared_size, expected_crc, data_byte
   input  wire logic [2:0]                  req_tuser,  // mode
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [23:0]                      rsp_tdata,  // byte_count
   output logic [3:0]                       rsp_tuser,  // event_res
   output logic                             rsp_tlast,  // last_result
   input  wire logic                        csr_we,
   input  wire logic [ulcc_pkg::CSR_AW-1:0] csr_addr,
   input  wire logic [ulcc_pkg::CSR_DW-1:0] csr_wdata
);

   ulcc_pkg::cfg_type    cfg_ff;
   ulcc_pkg::item_type   push_item, head_item;
   ulcc_pkg::result_type result;
   logic                 push, full, pop, head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_upload   <= ulcc_pkg::MAX_UPLOAD_RESET;
         cfg_ff.ack_every    <= ulcc_pkg::ACK_EVERY_RESET;
         cfg_ff.idle_timeout <= ulcc_pkg::IDLE_TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            ulcc_pkg::REG_MAX_UPLOAD:   cfg_ff.max_upload   <= csr_wdata;
            ulcc_pkg::REG_ACK_EVERY:    cfg_ff.ack_every    <= csr_wdata[15:0];
            ulcc_pkg::REG_IDLE_TIMEOUT: cfg_ff.idle_timeout <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   ulcc_front u_front (
      .req_tvalid  (req_tvalid),
      .req_mode    (req_tuser),
      .req_payload (req_tdata),
      .cfg         (cfg_ff),
      .queue_full  (full),
      .req_ready   (req_tready),
      .push        (push),
      .item        (push_item)
   );

   ulcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   ulcc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_result (result),
      .rsp_ready  (rsp_tready)
   );

   assign rsp_tdata = result.count;
   assign rsp_tuser = result.ev;
   assign rsp_tlast = result.last;

endmodule
`default_nettype wire

### tb/upload_length_crc_checker_core_test.sv
// Self-checking stream testbench for the upload length and CRC-32 checker core.
module upload_length_crc_checker_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ulcc_pkg::*;

   localparam int IDLE_PERCENT = 6;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [CSR_AW-1:0] REG_UNUSED = 2'd3;
   localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] size;
      logic [31:0] crc;
      logic [7:0]  data;
   } upload_item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [71:0]       req_tdata = '0;   // declared_size, expected_crc, data_byte
   logic [2:0]        req_tuser = '0;   // mode
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [23:0]       rsp_tdata;        // byte_count
   logic [3:0]        rsp_tuser;        // event_res
   logic              rsp_tlast;
   logic              csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   upload_item_type upload_items[$];
   result_type      pending_events[$];
   int              items_queued = 0;
   int              error_count = 0;
   int              stall_cycles = 0;
   bit              no_idle = 1'b0;

   // mirror of the block's registers and upload state
   logic [23:0] cfg_max_upload   = MAX_UPLOAD_RESET;
   logic [15:0] cfg_ack_every    = ACK_EVERY_RESET;
   logic [15:0] cfg_idle_timeout = IDLE_TIMEOUT_RESET;
   bit          upload_open = 1'b0;
   logic [23:0] want_size = '0;
   logic [31:0] want_crc = '0;
   logic [31:0] crc_so_far = '0;
   logic [23:0] byte_total = '0;
   logic [15:0] chunk_count = '0;
   logic [16:0] tick_count = '0;

   upload_length_crc_checker_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10ns clock = ~clock;

   // finished CRC-32 (reflected, all-ones init, inverted) advanced by one byte
   function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = ~crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return ~c;
   endfunction

   function automatic void predict_upload_events(input logic [2:0] mode, input logic [31:0] size,
                                                 input logic [31:0] crc, input logic [7:0] data);
      result_type found[$];
      case (mode)
         MODE_BEGIN: begin
            if (upload_open) begin
               upload_open = 1'b0;
               found.push_back('{EV_RESTARTED, byte_total, 1'b0});
            end
            if (size == 32'd0 || size > {8'd0, cfg_max_upload}) begin
               found.push_back('{EV_BAD_SIZE, size[23:0], 1'b0});
            end else begin
               want_size   = size[23:0];
               want_crc    = crc;
               crc_so_far  = '0;
               byte_total  = '0;
               chunk_count = '0;
               tick_count  = '0;
               upload_open = 1'b1;
               found.push_back('{EV_ACK, 24'd0, 1'b0});
            end
         end
         MODE_DATA, MODE_DATA_END: begin
            if (upload_open) begin
               tick_count = '0;
               if ({1'b0, byte_total} + 25'd1 > {1'b0, want_size}) begin
                  upload_open = 1'b0;
                  found.push_back('{EV_TOO_LONG, byte_total, 1'b0});
               end else begin
                  crc_so_far = crc32_next(crc_so_far, data);
                  byte_total = byte_total + 24'd1;
                  if (mode == MODE_DATA_END) begin
                     chunk_count = chunk_count + 16'd1;
                     if (chunk_count >= cfg_ack_every) begin
                        chunk_count = '0;
                        found.push_back('{EV_ACK, byte_total, 1'b0});
                     end
                  end
               end
            end
         end
         MODE_END: begin
            if (!upload_open) begin
               found.push_back('{EV_NO_UPLOAD, 24'd0, 1'b0});
            end else begin
               upload_open = 1'b0;
               if (byte_total != want_size)
                  found.push_back('{EV_SHORT, byte_total, 1'b0});
               else if (crc_so_far != want_crc)
                  found.push_back('{EV_CHECKSUM, byte_total, 1'b0});
               else
                  found.push_back('{EV_OK, byte_total, 1'b0});
            end
         end
         MODE_TICK: begin
            if (upload_open) begin
               if (tick_count <= {1'b0, cfg_idle_timeout}) tick_count = tick_count + 17'd1;
               if (tick_count > {1'b0, cfg_idle_timeout}) begin
                  upload_open = 1'b0;
                  found.push_back('{EV_TIMEOUT, byte_total, 1'b0});
               end
            end
         end
         default: ;
      endcase
      if (found.size() != 0) found[found.size() - 1].last = 1'b1;
      foreach (found[k]) pending_events.push_back(found[k]);
   endfunction

   task automatic check_event();
      result_type want;
      if (pending_events.size() == 0) begin
         $error("unexpected result: event_res %0d byte_count %0d", rsp_tuser, rsp_tdata);
         error_count++;
      end else begin
         want = pending_events.pop_front();
         if (rsp_tuser !== want.ev) begin
            $error("event_res: expected %0d, got %0d", want.ev, rsp_tuser);
            error_count++;
         end
         if (rsp_tdata !== want.count) begin
            $error("byte_count: expected %0d, got %0d", want.count, rsp_tdata);
            error_count++;
         end
         if (rsp_tlast !== want.last) begin
            $error("last_result: expected %0d, got %0d", want.last, rsp_tlast);
            error_count++;
         end
      end
   endtask

   // request driver
   always @(posedge clock) begin : driver
      upload_item_type next;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            predict_upload_events(req_tuser, req_tdata[31:0], req_tdata[63:32], req_tdata[71:64]);
         if (!req_tvalid || req_tready) begin
            if (upload_items.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
               next = upload_items.pop_front();
               req_tuser  <= next.mode;
               req_tdata  <= {next.data, next.crc, next.size};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_event();
         rsp_tready <= no_idle || $urandom_range(99) >= IDLE_PERCENT;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("upload_length_crc_checker_core_test NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic void push_item(input logic [2:0] mode, input logic [31:0] size,
                                     input logic [31:0] crc, input logic [7:0] data);
      upload_items.push_back('{mode, size, crc, data});
      if (mode <= MODE_TICK) items_queued++;
   endfunction

   task automatic write_reg(input logic [CSR_AW-1:0] idx, input logic [CSR_DW-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_MAX_UPLOAD:   cfg_max_upload   = value;
         REG_ACK_EVERY:    cfg_ack_every    = value[15:0];
         REG_IDLE_TIMEOUT: cfg_idle_timeout = value[15:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [23:0] max_size, input logic [15:0] ack_every,
                             input logic [15:0] timeout);
      write_reg(REG_MAX_UPLOAD, max_size);
      write_reg(REG_ACK_EVERY, {8'($urandom), ack_every});
      write_reg(REG_IDLE_TIMEOUT, {8'($urandom), timeout});
      write_reg(REG_UNUSED, 24'($urandom));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (upload_items.size() != 0 || req_tvalid || pending_events.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // begin, len payload bytes with random chunk ends and stray ticks, optional end
   task automatic queue_upload(input int len, input logic [31:0] declared, input bit crc_good,
                               input bit close_it);
      logic [7:0]  payload[$];
      logic [31:0] crc;
      logic [2:0]  data_mode;
      crc = '0;
      for (int k = 0; k < len; k++) begin
         payload.push_back(8'($urandom));
         crc = crc32_next(crc, payload[k]);
      end
      if (!crc_good) crc = crc ^ (32'd1 << $urandom_range(31, 0));
      push_item(MODE_BEGIN, declared, crc, 8'($urandom));
      foreach (payload[k]) begin
         if ($urandom_range(99) < 8)
            repeat ($urandom_range(3, 1)) push_item(MODE_TICK, $urandom, $urandom, 8'($urandom));
         data_mode = (k == len - 1 || $urandom_range(3, 0) == 0) ? MODE_DATA_END : MODE_DATA;
         push_item(data_mode, $urandom, $urandom, payload[k]);
      end
      if (close_it) push_item(MODE_END, $urandom, $urandom, 8'($urandom));
   endtask

   task automatic queue_random(input int count);
      int          goal;
      int          pick;
      int          cap;
      int          len;
      logic [31:0] declared;
      goal = items_queued + count;
      while (items_queued < goal) begin
         cap = (cfg_max_upload < 24) ? int'(cfg_max_upload) : 24;
         if ($urandom_range(99) < 72) begin
            len  = $urandom_range(cap, 1);
            pick = $urandom_range(99);
            if (pick < 65)      declared = len;
            else if (pick < 75) declared = len - 1;
            else if (pick < 85) declared = len + $urandom_range(3, 1);
            else if (pick < 92) declared = {8'd0, cfg_max_upload};
            else if (pick < 96) declared = {8'd0, cfg_max_upload} + 32'd1;
            else                declared = $urandom;
            pick = $urandom_range(99);
            queue_upload(len, declared, $urandom_range(99) < 85, pick < 88);
            if (pick >= 94) begin
               if (cfg_idle_timeout <= 64)
                  repeat (int'(cfg_idle_timeout) + 1)
                     push_item(MODE_TICK, $urandom, $urandom, 8'($urandom));
               else
                  push_item(MODE_END, $urandom, $urandom, 8'($urandom));
            end
         end else begin
            repeat ($urandom_range(4, 1))
               push_item(3'($urandom_range(7, 0)),
                         ($urandom_range(1, 0) != 0) ? $urandom : $urandom_range(cap + 2, 0),
                         $urandom, 8'($urandom));
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, reset register values
      push_item(MODE_END, '0, '0, 8'h00);
      push_item(MODE_DATA, '1, '1, 8'hFF);
      push_item(MODE_TICK, '0, '0, 8'h00);
      for (logic [3:0] m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
         push_item(m[2:0], '1, '1, 8'hFF);
      push_item(MODE_BEGIN, 32'd0, '0, 8'h00);
      push_item(MODE_BEGIN, 32'hFFFF_FFFF, '1, 8'hFF);
      push_item(MODE_BEGIN, {8'd0, MAX_UPLOAD_RESET} + 32'd1, '0, 8'h00);
      push_item(MODE_BEGIN, {8'd0, MAX_UPLOAD_RESET}, '1, 8'h00);
      queue_upload(2, 32'd2, 1'b1, 1'b0);                        // restarts the open upload
      push_item(MODE_DATA, '0, '0, 8'h00);                       // one byte too many
      push_item(MODE_END, '0, '0, 8'h00);
      queue_upload(3, 32'd5, 1'b1, 1'b1);                        // short
      queue_upload(1, 32'd1, 1'b0, 1'b1);                        // checksum
      queue_upload(4, 32'd4, 1'b1, 1'b1);                        // ok
      queue_random(240);
      wait_drained();

      set_config(24'd1, 16'd1, 16'd1);
      queue_random(150);
      wait_drained();

      no_idle = 1'b1;
      set_config(24'hFF_FFFF, 16'hFFFF, 16'hFFFF);
      queue_upload(3, 32'h00FF_FFFF, 1'b1, 1'b1);
      push_item(MODE_BEGIN, 32'h0100_0000, '1, 8'hFF);
      queue_random(200);
      wait_drained();
      no_idle = 1'b0;

      set_config(24'd20, 16'd0, 16'd3);                          // ack on every chunk
      queue_random(250);
      wait_drained();

      set_config(24'($urandom_range(40, 8)), 16'($urandom_range(5, 2)),
                 16'($urandom_range(30, 2)));
      queue_random(400);
      wait_drained();

      if (error_count == 0)
         $display("upload_length_crc_checker_core_test OK");
      else
         $display("upload_length_crc_checker_core_test NOT OK");
      $finish;
   end
endmodule

### sim.f
rtl/ulcc_pkg.sv
rtl/ulcc_queue.sv
rtl/ulcc_front.sv
rtl/ulcc_back.sv
rtl/upload_length_crc_checker_core.sv
tb/upload_length_crc_checker_core_test.sv
